>>> hdl/tcw_pkg.sv
// tcw_pkg: geometry, character codes, word types and codes shared by the
// text console writer modules
// depends on nothing
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int CELL_W  = $clog2(CELLS);

  // character codes
  localparam logic [7:0] CH_NEWLINE    = 8'd10;
  localparam logic [7:0] CH_BLANK_HERE = 8'd8;
  localparam logic [7:0] CH_ERROR      = 8'd69;
  localparam logic [7:0] CH_SPACE      = 8'd32;

  // register reset values
  localparam logic [7:0] DEF_ATTR_RST = 8'd15;
  localparam logic [7:0] ERR_ATTR_RST = 8'd244;

  // operation codes of an input word
  localparam logic [1:0] OP_PUT       = 2'd0;
  localparam logic [1:0] OP_BACKSPACE = 2'd1;
  localparam logic [1:0] OP_READ      = 2'd2;
  localparam logic [1:0] OP_NOP       = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ATTR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_ATTR   = 1'b1;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic       use_cursor;
    logic [7:0] column;
    logic [7:0] line;
  } in_word_t;

  typedef struct packed {
    logic [6:0] cursor_column;
    logic [4:0] cursor_row;
    logic       coord_error;
    logic       scrolled;
    logic [7:0] cell_char;
    logic [7:0] cell_attribute;
  } out_word_t;

  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] ch;
  } cell_t;

  localparam cell_t CELL_RST = {DEF_ATTR_RST, CH_SPACE};

  // classified command passed from front to back
  typedef enum logic [2:0] {
    K_PUT,
    K_NEWLINE,
    K_BLANK,
    K_BACKSPACE,
    K_ERR_PUT,
    K_READ,
    K_ERR_READ,
    K_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic             use_cursor;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [7:0]       ch;
    logic [7:0]       attr;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL
  } back_state_t;

endpackage

>>> hdl/tcw_front.sv
// tcw_front: configuration registers and classification of input words
// depends on tcw_pkg
module tcw_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tcw_pkg::in_word_t              in_data,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data,
  output tcw_pkg::cmd_t                  cmd
);
  import tcw_pkg::*;

  logic [7:0] def_attr_r;
  logic [7:0] err_attr_r;
  logic       pos_ok;
  logic [7:0] attr_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_attr_r <= DEF_ATTR_RST;
      err_attr_r <= ERR_ATTR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEFAULT_ATTR: def_attr_r <= cfg_data;
        CFG_ERROR_ATTR:   err_attr_r <= cfg_data;
      endcase
    end
  end

  assign pos_ok   = in_data.use_cursor ||
                    ((in_data.column < 8'(COLUMNS)) && (in_data.line < 8'(ROWS)));
  assign attr_eff = (in_data.attribute == 8'd0) ? def_attr_r : in_data.attribute;

  always_comb begin
    cmd.kind       = K_NOP;
    cmd.use_cursor = in_data.use_cursor;
    cmd.col        = COL_W'(in_data.column);
    cmd.row        = ROW_W'(in_data.line);
    cmd.ch         = in_data.char_code;
    cmd.attr       = attr_eff;
    unique case (in_data.operation)
      OP_PUT: begin
        if (!pos_ok) begin
          // error mark goes into the last cell
          cmd.kind = K_ERR_PUT;
          cmd.ch   = CH_ERROR;
          cmd.attr = err_attr_r;
        end else if (in_data.char_code == CH_NEWLINE) begin
          cmd.kind = K_NEWLINE;
        end else if (in_data.char_code == CH_BLANK_HERE) begin
          cmd.kind = K_BLANK;
          cmd.ch   = CH_SPACE;
        end else begin
          cmd.kind = K_PUT;
        end
      end
      OP_BACKSPACE: begin
        cmd.kind = K_BACKSPACE;
        cmd.ch   = CH_SPACE;
        cmd.attr = def_attr_r;
      end
      OP_READ: begin
        cmd.kind = pos_ok ? K_READ : K_ERR_READ;
      end
      OP_NOP: begin
        cmd.kind = K_NOP;
      end
    endcase
  end

endmodule

>>> hdl/tcw_cmdq.sv
// tcw_cmdq: two-word command queue between front and back
// depends on tcw_pkg
module tcw_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcw_pkg::cmd_t push_cmd,
  input  logic          pop,
  output tcw_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import tcw_pkg::*;

  cmd_t       slot_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = slot_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_cmd;
  end

endmodule

>>> hdl/tcw_back.sv
// tcw_back: command executor with screen memory, cursor, row base pointer
// and two-word result queue
// depends on tcw_pkg
module tcw_back (
  input  logic               clk,
  input  logic               rst_n,
  input  tcw_pkg::cmd_t      cmd_head,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  output logic               clearing,
  output logic               out_empty,
  input  logic               out_pop,
  output tcw_pkg::out_word_t out_data
);
  import tcw_pkg::*;

  back_state_t state_r, state_nxt;
  cmd_t        cmd_r;

  logic [COL_W-1:0]  cur_col_r;
  logic [ROW_W-1:0]  cur_row_r;
  logic [ROW_W-1:0]  base_r;
  logic [CELL_W-1:0] clr_cnt_r;
  logic [COL_W-1:0]  scnt_r;
  logic [CELL_W-1:0] zaddr_r;

  // screen memory
  cell_t             mem [CELLS];
  cell_t             rd_q;
  logic              mem_we;
  logic              mem_re;
  logic [CELL_W-1:0] mem_waddr;
  cell_t             mem_wdata;

  // execute datapath
  logic [COL_W-1:0]  lcol, ncol;
  logic [ROW_W-1:0]  lrow, nrow, prow;
  logic [ROW_W:0]    psum;
  logic [CELL_W-1:0] exec_addr;
  logic              exec_wr;
  logic              exec_scroll;

  // result queue
  out_word_t  res_q_r [2];
  logic       res_wp_r;
  logic       res_rp_r;
  logic [1:0] res_cnt_r;
  logic       res_push;
  logic       res_pop;
  out_word_t  res_word;

  assign clearing = (state_r == ST_CLEAR);

  always_comb begin
    lcol        = cur_col_r;
    lrow        = cur_row_r;
    ncol        = cur_col_r;
    nrow        = cur_row_r;
    exec_wr     = 1'b0;
    exec_scroll = 1'b0;
    if (!cmd_r.use_cursor) begin
      lcol = cmd_r.col;
      lrow = cmd_r.row;
    end
    unique case (cmd_r.kind)
      K_PUT: begin
        exec_wr = 1'b1;
        if (lcol == COL_W'(COLUMNS - 1)) begin
          ncol = '0;
          if (lrow == ROW_W'(ROWS - 1)) begin
            nrow        = lrow;
            exec_scroll = 1'b1;
          end else begin
            nrow = lrow + 1'b1;
          end
        end else begin
          ncol = lcol + 1'b1;
          nrow = lrow;
        end
      end
      K_NEWLINE: begin
        ncol = '0;
        if (lrow == ROW_W'(ROWS - 1)) begin
          nrow        = lrow;
          exec_scroll = 1'b1;
        end else begin
          nrow = lrow + 1'b1;
        end
      end
      K_BLANK: begin
        exec_wr = 1'b1;
        ncol    = lcol;
        nrow    = lrow;
      end
      K_BACKSPACE: begin
        // step back one cell, stopping at the first one
        exec_wr = 1'b1;
        if (cur_col_r != '0) begin
          lcol = cur_col_r - 1'b1;
          lrow = cur_row_r;
        end else if (cur_row_r != '0) begin
          lcol = COL_W'(COLUMNS - 1);
          lrow = cur_row_r - 1'b1;
        end else begin
          lcol = '0;
          lrow = '0;
        end
        ncol = lcol;
        nrow = lrow;
      end
      K_ERR_PUT: begin
        exec_wr = 1'b1;
        lcol    = COL_W'(COLUMNS - 1);
        lrow    = ROW_W'(ROWS - 1);
      end
      default: begin
      end
    endcase
  end

  // logical row to physical row through the base pointer
  assign psum      = {1'b0, base_r} + {1'b0, lrow};
  assign prow      = (psum >= (ROW_W+1)'(ROWS)) ? ROW_W'(psum - (ROW_W+1)'(ROWS))
                                                : ROW_W'(psum);
  assign exec_addr = CELL_W'(prow) * CELL_W'(COLUMNS) + CELL_W'(lcol);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_cnt_r == CELL_W'(CELLS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (!cmd_empty && (res_cnt_r != 2'd2)) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (cmd_r.kind == K_READ) state_nxt = ST_READ;
        else if (exec_scroll) state_nxt = ST_SCROLL;
        else state_nxt = ST_IDLE;
      end
      ST_READ:   state_nxt = ST_IDLE;
      ST_SCROLL: if (scnt_r == COL_W'(COLUMNS - 1)) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    cmd_pop   = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = exec_addr;
    mem_wdata = {cmd_r.attr, cmd_r.ch};
    res_push  = 1'b0;
    res_word.cursor_column  = 7'(ncol);
    res_word.cursor_row     = 5'(nrow);
    res_word.coord_error    = (cmd_r.kind == K_ERR_PUT) || (cmd_r.kind == K_ERR_READ);
    res_word.scrolled       = exec_scroll;
    res_word.cell_char      = 8'd0;
    res_word.cell_attribute = 8'd0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = CELL_RST;
      end
      ST_IDLE: begin
        cmd_pop = !cmd_empty && (res_cnt_r != 2'd2);
      end
      ST_EXEC: begin
        mem_we   = exec_wr;
        mem_re   = (cmd_r.kind == K_READ);
        res_push = (cmd_r.kind != K_READ);
      end
      ST_READ: begin
        res_push = 1'b1;
        res_word.cursor_column  = 7'(cur_col_r);
        res_word.cursor_row     = 5'(cur_row_r);
        res_word.coord_error    = 1'b0;
        res_word.scrolled       = 1'b0;
        res_word.cell_char      = rd_q.ch;
        res_word.cell_attribute = rd_q.attr;
      end
      ST_SCROLL: begin
        mem_we    = 1'b1;
        mem_waddr = zaddr_r;
        mem_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem[exec_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      cur_col_r <= '0;
      cur_row_r <= '0;
      base_r    <= '0;
      scnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (state_r == ST_EXEC) begin
        cur_col_r <= ncol;
        cur_row_r <= nrow;
        if (exec_scroll) begin
          // old top row becomes the new bottom row
          base_r <= (base_r == ROW_W'(ROWS - 1)) ? '0 : base_r + 1'b1;
          scnt_r <= '0;
        end
      end
      if (state_r == ST_SCROLL) scnt_r <= scnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) cmd_r <= cmd_head;
    if (state_r == ST_EXEC) zaddr_r <= CELL_W'(base_r) * CELL_W'(COLUMNS);
    else if (state_r == ST_SCROLL) zaddr_r <= zaddr_r + 1'b1;
  end

  // result queue
  assign res_pop   = out_pop && (res_cnt_r != 2'd0);
  assign out_empty = (res_cnt_r == 2'd0);
  assign out_data  = res_q_r[res_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wp_r  <= 1'b0;
      res_rp_r  <= 1'b0;
      res_cnt_r <= 2'd0;
    end else begin
      if (res_push) res_wp_r <= ~res_wp_r;
      if (res_pop) res_rp_r <= ~res_rp_r;
      case ({res_push, res_pop})
        2'b10:   res_cnt_r <= res_cnt_r + 2'd1;
        2'b01:   res_cnt_r <= res_cnt_r - 2'd1;
        default: res_cnt_r <= res_cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) res_q_r[res_wp_r] <= res_word;
  end

endmodule

>>> hdl/text_console_writer_core.sv
// channel  ports                          word type        accepted when
// in       in_push in_full in_data        in_word_t        in_push & !in_full
// out      out_empty out_pop out_data     out_word_t       out_pop & !out_empty
// cfg      cfg_we cfg_index cfg_data      8-bit register   cfg_we
//
// a word passes the back end in ST_IDLE (dequeue) and ST_EXEC (execute); a read
// also passes ST_READ, since the screen memory has a registered read port
// a scroll then zeroes the new bottom row in ST_SCROLL through the
// single write port; rows themselves are never copied, a row base pointer moves
// after reset a clearing pass writes every one of the CELLS cells while
// in_full stays high; cfg writes are taken during it
// two-word command and result queues let the input and the output stall
// independently of the executor
//
// text console writer top level: front classifier, command queue, back end
// depends on tcw_pkg, tcw_front, tcw_cmdq, tcw_back
module text_console_writer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // input words
  input  logic                           in_push,
  output logic                           in_full,
  input  tcw_pkg::in_word_t              in_data,
  // result words
  output logic                           out_empty,
  input  logic                           out_pop,
  output tcw_pkg::out_word_t             out_data,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tcw_pkg::*;

  cmd_t cls_cmd;     // classified incoming word
  cmd_t q_head;      // oldest queued command
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic q_push;
  logic clearing;

  // no word enters while the screen is being cleared after reset
  assign in_full = q_full || clearing;
  assign q_push  = in_push && !in_full;

  // range check, attribute defaulting and decode of the operation
  tcw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cls_cmd)
  );

  // decouples the input handshake from the executor
  tcw_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (cls_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // screen memory, cursor, scrolling and result queue
  tcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_head  (q_head),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .clearing  (clearing),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

>>> hdl/tcw_checker.sv
// tcw_checker: port-level assertions for the text console writer, bound to
// the top level
// depends on tcw_pkg, text_console_writer_core
module tcw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input tcw_pkg::out_word_t out_data
);
  import tcw_pkg::*;

  // leaving reset the block is clearing and has no result
  a_reset_clear: assert property (@(posedge clk)
    $rose(rst_n) |-> (in_full && out_empty))
    else $error("no clearing pass or stale result after reset");

  // reported cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_data.cursor_column < 7'(COLUMNS)) &&
                    (out_data.cursor_row < 5'(ROWS))))
    else $error("cursor outside the screen");

  // an error word neither scrolls nor carries cell data
  a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.coord_error) |->
      (!out_data.scrolled && (out_data.cell_char == 8'd0) &&
       (out_data.cell_attribute == 8'd0)))
    else $error("error word with scroll or cell data");

  // a waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed or vanished");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
